### sv/sce_pkg.sv
`timescale 1ns / 1ps

package sce_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int SEQ_W  = 16;
    localparam int IDX_W  = 4;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic REG_HEADER_BYTE = 1'b0;
    localparam logic REG_TAIL_BYTE   = 1'b1;

    localparam logic [IDX_W-1:0] IDX_HDR0   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_HDR1   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_ZERO   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_SEQ_HI = 4'd3;
    localparam logic [IDX_W-1:0] IDX_SEQ_LO = 4'd4;
    localparam logic [IDX_W-1:0] IDX_LEN_HI = 4'd5;
    localparam logic [IDX_W-1:0] IDX_BODY   = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CHK    = 4'd7;
    localparam logic [IDX_W-1:0] IDX_TAIL0  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_TAIL1  = 4'd9;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd85;

    typedef struct packed {
        logic              is_start;
        logic              closes;
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] len_hi;
        logic [BYTE_W-1:0] body;
        logic [BYTE_W-1:0] chk;
    } sce_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] tail;
    } sce_cfg_t;

endpackage

### sv/sce_front.sv
`timescale 1ns / 1ps

module sce_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic                         in_op,
    input  logic [sce_pkg::LEN_W-1:0]    in_len,
    input  logic [sce_pkg::BYTE_W-1:0]   in_byte,
    output logic                         push,
    output sce_pkg::sce_cmd_t            push_cmd
);

    logic [sce_pkg::SEQ_W-1:0]  seq_reg, seq_next;
    logic [sce_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic [sce_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic                       open_reg, open_next;
    logic [sce_pkg::LEN_W-1:0]  rem_dec;
    logic [sce_pkg::BYTE_W-1:0] hdr_sum;

    assign rem_dec = rem_reg - 16'd1;
    assign hdr_sum = seq_reg[15:8] + seq_reg[7:0] + in_len[15:8] + in_len[7:0];

    always_comb begin
        seq_next  = seq_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        open_next = open_reg;
        push      = 1'b0;
        push_cmd.is_start = (in_op == sce_pkg::OP_START);
        push_cmd.closes   = 1'b0;
        push_cmd.seq      = seq_reg;
        push_cmd.len_hi   = in_len[15:8];
        push_cmd.body     = (in_op == sce_pkg::OP_START) ? in_len[7:0] : in_byte;
        push_cmd.chk      = hdr_sum;
        if (in_fire) begin
            if (in_op == sce_pkg::OP_START) begin
                push     = 1'b1;
                sum_next = hdr_sum;
                if (in_len == '0) begin
                    push_cmd.closes = 1'b1;
                    seq_next  = seq_reg + 16'd1;
                    rem_next  = '0;
                    open_next = 1'b0;
                end else begin
                    rem_next  = in_len;
                    open_next = 1'b1;
                end
            end else if (open_reg) begin
                push         = 1'b1;
                sum_next     = sum_reg + in_byte;
                push_cmd.chk = sum_reg + in_byte;
                rem_next     = rem_dec;
                if (rem_dec == '0) begin
                    push_cmd.closes = 1'b1;
                    seq_next  = seq_reg + 16'd1;
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg  <= '0;
            sum_reg  <= '0;
            rem_reg  <= '0;
            open_reg <= 1'b0;
        end else begin
            seq_reg  <= seq_next;
            sum_reg  <= sum_next;
            rem_reg  <= rem_next;
            open_reg <= open_next;
        end
    end

`ifndef ASSERT_OFF
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> rem_reg != '0)
        else $error("open frame with no bytes left");
`endif

endmodule

### sv/sce_queue.sv
`timescale 1ns / 1ps

module sce_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sce_pkg::sce_cmd_t push_cmd,
    input  logic              pop,
    output sce_pkg::sce_cmd_t head,
    output logic              empty,
    output logic              full
);

    sce_pkg::sce_cmd_t mem [sce_pkg::Q_DEPTH];
    logic [sce_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sce_pkg::Q_CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == sce_pkg::Q_CNT_W'(sce_pkg::Q_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + sce_pkg::Q_CNT_W'(push) - sce_pkg::Q_CNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue underflow");
`endif

endmodule

### sv/sce_back.sv
`timescale 1ns / 1ps

module sce_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sce_pkg::sce_cfg_t           cfg,
    input  sce_pkg::sce_cmd_t           head,
    input  logic                        empty,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sce_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    logic                        mid_reg;
    logic [sce_pkg::IDX_W-1:0]   step_reg;
    logic                        valid_reg;
    logic [sce_pkg::BYTE_W-1:0]  data_reg;
    logic                        last_reg;
    logic                        end_reg;
    logic [sce_pkg::IDX_W-1:0]   cur_idx;
    logic [sce_pkg::IDX_W-1:0]   end_idx;
    logic [sce_pkg::BYTE_W-1:0]  cur_byte;
    logic                        advance;
    logic                        at_end;

    assign cur_idx = mid_reg ? step_reg
                   : (head.is_start ? sce_pkg::IDX_HDR0 : sce_pkg::IDX_BODY);
    assign end_idx = head.closes ? sce_pkg::IDX_TAIL1 : sce_pkg::IDX_BODY;
    assign at_end  = (cur_idx == end_idx);
    assign advance = !empty && (!valid_reg || m_tready);
    assign pop     = advance && at_end;

    always_comb begin
        unique case (cur_idx)
            sce_pkg::IDX_HDR0,
            sce_pkg::IDX_HDR1:   cur_byte = cfg.header;
            sce_pkg::IDX_ZERO:   cur_byte = '0;
            sce_pkg::IDX_SEQ_HI: cur_byte = head.seq[15:8];
            sce_pkg::IDX_SEQ_LO: cur_byte = head.seq[7:0];
            sce_pkg::IDX_LEN_HI: cur_byte = head.len_hi;
            sce_pkg::IDX_BODY:   cur_byte = head.body;
            sce_pkg::IDX_CHK:    cur_byte = head.chk;
            sce_pkg::IDX_TAIL0,
            sce_pkg::IDX_TAIL1:  cur_byte = cfg.tail;
            default:             cur_byte = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg   <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                valid_reg <= 1'b1;
                if (at_end) begin
                    mid_reg <= 1'b0;
                end else begin
                    mid_reg  <= 1'b1;
                    step_reg <= cur_idx + 4'd1;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= cur_byte;
            last_reg <= at_end;
            end_reg  <= (cur_idx == sce_pkg::IDX_TAIL1);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = end_reg;

`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && end_reg) |-> last_reg)
        else $error("frame end not marked last");
`endif

endmodule

### sv/sum_checked_frame_encoder.sv
`timescale 1ns / 1ps
// Channel  | Ports                       | Contents
// input    | s_tvalid/s_tready/s_tdata   | tdata: message_length[15:0], payload_byte[23:16]
//          | s_tuser                     | operation
// output   | m_tvalid/m_tready/m_tdata   | tdata: out_byte[7:0]; tlast: last_of_run
//          | m_tuser                     | frame_end
// config   | cfg_wr_en/cfg_addr/cfg_wdata| 0 header_byte, 1 tail_byte
//
// One output byte per cycle from the back sequencer unless the queue is empty or output stalls:
// a payload byte yields one byte, a start seven (ten for zero length), a closing payload byte four.
// Input is taken while the four-entry command queue has room, one item per cycle.
// aresetn is synchronous, active low; it clears frame state and the queue.
// Output stalls hold the output register and fill the queue, then drop s_tready.
module sum_checked_frame_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // message_length[15:0], payload_byte[23:16]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser,   // frame_end
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    sce_pkg::sce_cfg_t cfg_reg;
    sce_pkg::sce_cmd_t push_cmd;
    sce_pkg::sce_cmd_t head;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;
    logic              in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header <= sce_pkg::HEADER_RESET;
            cfg_reg.tail   <= sce_pkg::TAIL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sce_pkg::REG_HEADER_BYTE: cfg_reg.header <= cfg_wdata;
                sce_pkg::REG_TAIL_BYTE:   cfg_reg.tail   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    sce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_op    (s_tuser),
        .in_len   (s_tdata[15:0]),
        .in_byte  (s_tdata[23:16]),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    sce_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/sum_checked_frame_encoder_tb.sv
`timescale 1ns / 1ps

module sum_checked_frame_encoder_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 24;

    typedef struct packed {
        logic                       op;
        logic [sce_pkg::LEN_W-1:0]  len;
        logic [sce_pkg::BYTE_W-1:0] pb;
    } enc_item_t;

    typedef struct packed {
        logic [sce_pkg::BYTE_W-1:0] data;
        logic                       last;
        logic                       fend;
    } enc_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // message_length[15:0], payload_byte[23:16]
    logic        s_tuser   = sce_pkg::OP_START;   // operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // out_byte[7:0]
    logic        m_tlast;
    logic        m_tuser;          // frame_end
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = sce_pkg::REG_HEADER_BYTE;
    logic [7:0]  cfg_wdata = '0;

    sum_checked_frame_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    enc_item_t tx_items[$];
    enc_byte_t expected_bytes[$];
    enc_item_t drv_item;
    logic      in_taken = 1'b0;
    int        send_idle_pct = 14;
    int        recv_idle_pct = 78;
    int        rx_hold_reqs = 0;
    int        rx_hold_done = 0;
    int        rx_hold_left = 0;
    int        cycles = 0;
    int        errors = 0;

    // encoder state as the block should hold it
    logic [sce_pkg::BYTE_W-1:0] enc_header = sce_pkg::HEADER_RESET;
    logic [sce_pkg::BYTE_W-1:0] enc_tail   = sce_pkg::TAIL_RESET;
    logic [sce_pkg::SEQ_W-1:0]  enc_seq    = '0;
    logic [sce_pkg::BYTE_W-1:0] enc_sum    = '0;
    logic [sce_pkg::LEN_W-1:0]  enc_left   = '0;
    logic                       enc_open   = 1'b0;

    function automatic enc_byte_t mk_byte(logic [sce_pkg::BYTE_W-1:0] d, logic fe);
        enc_byte_t b;
        b.data = d;
        b.last = 1'b0;
        b.fend = fe;
        return b;
    endfunction

    task automatic encode_item(input enc_item_t it);
        enc_byte_t burst[$];
        enc_byte_t b;
        logic      closing;
        closing = 1'b0;
        if (it.op == sce_pkg::OP_START) begin
            burst.push_back(mk_byte(enc_header, 1'b0));
            burst.push_back(mk_byte(enc_header, 1'b0));
            burst.push_back(mk_byte(8'h00, 1'b0));
            burst.push_back(mk_byte(enc_seq[15:8], 1'b0));
            burst.push_back(mk_byte(enc_seq[7:0], 1'b0));
            burst.push_back(mk_byte(it.len[15:8], 1'b0));
            burst.push_back(mk_byte(it.len[7:0], 1'b0));
            enc_sum  = enc_seq[15:8] + enc_seq[7:0] + it.len[15:8] + it.len[7:0];
            enc_left = it.len;
            enc_open = 1'b1;
            closing  = (it.len == '0);
        end else if (enc_open) begin
            burst.push_back(mk_byte(it.pb, 1'b0));
            enc_sum  = enc_sum + it.pb;
            enc_left = enc_left - 1'b1;
            closing  = (enc_left == '0);
        end
        if (closing) begin
            burst.push_back(mk_byte(enc_sum, 1'b0));
            burst.push_back(mk_byte(enc_tail, 1'b0));
            burst.push_back(mk_byte(enc_tail, 1'b1));
            enc_seq  = enc_seq + 1'b1;
            enc_open = 1'b0;
            enc_left = '0;
        end
        for (int i = 0; i < burst.size(); i++) begin
            b = burst[i];
            b.last = (i == burst.size() - 1);
            expected_bytes.push_back(b);
        end
    endtask

    // sender: hold the item until taken, then advance or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (tx_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item = tx_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drv_item.pb, drv_item.len};
                s_tuser  <= drv_item.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            encode_item(drv_item);
            in_taken = 1'b1;
        end
    end

    // receiver: long hold on request, random stalls otherwise
    always @(negedge aclk) begin
        if (rx_hold_reqs != rx_hold_done) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_done = rx_hold_reqs;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        enc_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got byte %02h last %0b end %0b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %02h got %02h", $time, want.data, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last_of_run expected %0b got %0b", $time, want.last, m_tlast);
                end
                if (m_tuser !== want.fend) begin
                    errors++;
                    $display("%0t: frame_end expected %0b got %0b", $time, want.fend, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_start(input logic [sce_pkg::LEN_W-1:0] len);
        enc_item_t it;
        it.op  = sce_pkg::OP_START;
        it.len = len;
        it.pb  = sce_pkg::BYTE_W'($urandom_range(0, 255));
        tx_items.push_back(it);
    endtask

    task automatic push_payload(input logic [sce_pkg::BYTE_W-1:0] pb);
        enc_item_t it;
        it.op  = sce_pkg::OP_PAYLOAD;
        it.len = sce_pkg::LEN_W'($urandom_range(0, 65535));
        it.pb  = pb;
        tx_items.push_back(it);
    endtask

    task automatic queue_frame(input int len, input int n_bytes);
        push_start(sce_pkg::LEN_W'(len));
        for (int i = 0; i < n_bytes; i++)
            push_payload(sce_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    // mostly complete frames, some abandoned or cut short, a few stray bytes
    task automatic queue_traffic(input int n_items);
        int made;
        int r;
        int len;
        int cnt;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(0, 6);
                queue_frame(len, len);
                made += len + 1;
            end else if (r < 82) begin
                len = $urandom_range(0, 65535);
                cnt = $urandom_range(0, 3);
                queue_frame(len, cnt);
                made += cnt + 1;
            end else if (r < 92) begin
                len = $urandom_range(2, 8);
                cnt = $urandom_range(0, len - 1);
                queue_frame(len, cnt);
                made += cnt + 1;
            end else begin
                push_payload(sce_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // wait for the queue and results to drain, then let dropped items settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (tx_items.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [sce_pkg::BYTE_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        if (addr == sce_pkg::REG_HEADER_BYTE)
            enc_header = val;
        else
            enc_tail = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_payload(8'h5A);
        queue_frame(0, 0);
        push_start(16'd1);
        push_payload(8'hFF);
        push_start(16'd2);
        push_payload(8'h00);
        push_payload(8'h80);
        push_start(16'hFFFF);
        push_payload(8'h01);
        push_start(16'd3);
        push_payload(8'h7F);
        push_payload(8'hFE);
        push_payload(8'hAA);
        push_payload(8'h11);
        push_start(16'h8000);
        push_start(16'h0100);
        push_start(16'h00FF);
        push_payload(8'h55);
        push_start(16'd1);
        push_payload(8'h00);
        wait_idle();

        write_reg(sce_pkg::REG_HEADER_BYTE, 8'h00);
        write_reg(sce_pkg::REG_TAIL_BYTE, 8'hFF);
        queue_traffic(65);
        rx_hold_reqs++;
        wait_idle();

        send_idle_pct = 78;
        recv_idle_pct = 14;
        write_reg(sce_pkg::REG_HEADER_BYTE, 8'hFF);
        write_reg(sce_pkg::REG_TAIL_BYTE, 8'h00);
        queue_traffic(65);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sce_pkg::REG_HEADER_BYTE, sce_pkg::BYTE_W'($urandom_range(0, 255)));
        write_reg(sce_pkg::REG_TAIL_BYTE, sce_pkg::BYTE_W'($urandom_range(0, 255)));
        queue_traffic(60);
        wait_idle();

        if (expected_bytes.size() != 0)
            errors++;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
